// ===== sv/trp_pkg.sv =====
// Shared types and constants for the telnet receive parser.
`timescale 1ns / 1ps

package trp_pkg;

  localparam int unsigned NumOpt = 3;

  // Telnet protocol bytes
  localparam logic [7:0] BYTE_IAC  = 8'd255;
  localparam logic [7:0] BYTE_DONT = 8'd254;
  localparam logic [7:0] BYTE_DO   = 8'd253;
  localparam logic [7:0] BYTE_WONT = 8'd252;
  localparam logic [7:0] BYTE_WILL = 8'd251;
  localparam logic [7:0] BYTE_SB   = 8'd250;
  localparam logic [7:0] BYTE_SE   = 8'd240;
  localparam logic [7:0] BYTE_CR   = 8'd13;
  localparam logic [7:0] BYTE_NUL  = 8'd0;

  // Configuration register indexes
  localparam logic [2:0] CFG_CODE_A   = 3'd0;
  localparam logic [2:0] CFG_CODE_B   = 3'd1;
  localparam logic [2:0] CFG_CODE_C   = 3'd2;
  localparam logic [2:0] CFG_POLICY_A = 3'd3;
  localparam logic [2:0] CFG_POLICY_B = 3'd4;
  localparam logic [2:0] CFG_POLICY_C = 3'd5;

  // Policy flag bit positions
  localparam int unsigned POL_ACCEPT_WILL = 0;
  localparam int unsigned POL_ACCEPT_WONT = 1;
  localparam int unsigned POL_AGREE_DO    = 2;

  // Result kinds
  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_REPLY = 1'b1;

  typedef enum logic [1:0] {
    VERB_WILL = 2'd0,
    VERB_WONT = 2'd1,
    VERB_DO   = 2'd2,
    VERB_DONT = 2'd3
  } verb_e;

  typedef struct packed {
    logic [NumOpt-1:0][7:0] code;
    logic [NumOpt-1:0][2:0] policy;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic       kind;   // 0 data word, 1 negotiation reply
    logic [7:0] data;
    verb_e      verb;
  } result_t;

endpackage

// ===== sv/trp_cfg_regs.sv =====
// Configuration register bank: option table codes and policy flags.
`timescale 1ns / 1ps

module trp_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [7:0]    cfg_data_i,
  output trp_pkg::cfg_t cfg_o
);
  import trp_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_CODE_A:   cfg_d.code[0]   = cfg_data_i;
        CFG_CODE_B:   cfg_d.code[1]   = cfg_data_i;
        CFG_CODE_C:   cfg_d.code[2]   = cfg_data_i;
        CFG_POLICY_A: cfg_d.policy[0] = cfg_data_i[2:0];
        CFG_POLICY_B: cfg_d.policy[1] = cfg_data_i[2:0];
        CFG_POLICY_C: cfg_d.policy[2] = cfg_data_i[2:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code   <= {8'd0, 8'd1, 8'd3};
      cfg_q.policy <= {3'd3, 3'd7, 3'd3};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/trp_parser.sv =====
// Parse state machine and option negotiation, one word per step.
`timescale 1ns / 1ps

module trp_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  trp_pkg::cfg_t    cfg_i,
  output trp_pkg::result_t res_o
);
  import trp_pkg::*;

  typedef enum logic [5:0] {
    ST_NORMAL = 6'b000001,
    ST_CR     = 6'b000010,
    ST_IAC    = 6'b000100,
    ST_OPT    = 6'b001000,
    ST_SUB1   = 6'b010000,
    ST_SUB2   = 6'b100000
  } parse_state_e;

  parse_state_e       state_q, state_d;
  verb_e              verb_q, verb_d;
  logic [NumOpt-1:0]  sent_will_q, sent_will_d;
  logic [NumOpt-1:0]  sent_do_q, sent_do_d;

  logic [NumOpt-1:0]  hit, first;
  logic [2:0]         pol;
  logic               matched, will_sent, do_sent, is_peer_offer;
  parse_state_e       data_state;
  result_t            data_res, neg_res;

  // option table match, lowest entry wins; code 255 marks an empty entry
  always_comb begin
    for (int i = 0; i < NumOpt; i++) begin
      hit[i] = (cfg_i.code[i] != BYTE_IAC) && (cfg_i.code[i] == byte_i);
    end
    first[0] = hit[0];
    first[1] = hit[1] & ~hit[0];
    first[2] = hit[2] & ~hit[1] & ~hit[0];
    pol = 3'd0;
    for (int i = 0; i < NumOpt; i++) begin
      pol = pol | (cfg_i.policy[i] & {3{first[i]}});
    end
  end

  assign matched       = |hit;
  assign will_sent     = |(first & sent_will_q);
  assign do_sent       = |(first & sent_do_q);
  assign is_peer_offer = (verb_q == VERB_WILL) || (verb_q == VERB_WONT);

  always_comb begin
    neg_res       = '0;
    neg_res.kind  = KIND_REPLY;
    neg_res.data  = byte_i;
    neg_res.verb  = VERB_WILL;
    if (!matched) begin
      neg_res.valid = 1'b1;
      neg_res.verb  = is_peer_offer ? VERB_DONT : VERB_WONT;
    end else begin
      case (verb_q)
        VERB_WILL: begin
          neg_res.valid = ~do_sent;
          neg_res.verb  = pol[POL_ACCEPT_WILL] ? VERB_DO : VERB_DONT;
        end
        VERB_WONT: begin
          neg_res.valid = ~do_sent;
          neg_res.verb  = pol[POL_ACCEPT_WONT] ? VERB_DONT : VERB_DO;
        end
        default: begin
          neg_res.valid = ~will_sent;
          neg_res.verb  = pol[POL_AGREE_DO] ? VERB_WILL : VERB_WONT;
        end
      endcase
    end
  end

  // plain data handling, shared by normal and after-CR states
  always_comb begin
    data_res       = '0;
    data_res.kind  = KIND_DATA;
    data_res.data  = byte_i;
    data_res.verb  = VERB_WILL;
    data_res.valid = (byte_i != BYTE_IAC);
    if (byte_i == BYTE_IAC) begin
      data_state = ST_IAC;
    end else if (byte_i == BYTE_CR) begin
      data_state = ST_CR;
    end else begin
      data_state = ST_NORMAL;
    end
  end

  always_comb begin
    state_d     = state_q;
    verb_d      = verb_q;
    sent_will_d = sent_will_q;
    sent_do_d   = sent_do_q;
    res_o       = '0;
    res_o.verb  = VERB_WILL;
    case (state_q)
      ST_CR: begin
        if (byte_i == BYTE_NUL) begin
          state_d = ST_NORMAL;
        end else begin
          state_d = data_state;
          res_o   = data_res;
        end
      end
      ST_IAC: begin
        state_d = ST_NORMAL;
        if (byte_i == BYTE_IAC) begin
          res_o.valid = 1'b1;
          res_o.kind  = KIND_DATA;
          res_o.data  = BYTE_IAC;
        end else if (byte_i == BYTE_SB) begin
          state_d = ST_SUB1;
        end else if (byte_i == BYTE_WILL) begin
          verb_d  = VERB_WILL;
          state_d = ST_OPT;
        end else if (byte_i == BYTE_WONT) begin
          verb_d  = VERB_WONT;
          state_d = ST_OPT;
        end else if (byte_i == BYTE_DO) begin
          verb_d  = VERB_DO;
          state_d = ST_OPT;
        end else if (byte_i == BYTE_DONT) begin
          verb_d  = VERB_DONT;
          state_d = ST_OPT;
        end
      end
      ST_OPT: begin
        state_d = ST_NORMAL;
        res_o   = neg_res;
        if (is_peer_offer) begin
          sent_do_d = sent_do_q ^ first;
        end else begin
          sent_will_d = sent_will_q ^ first;
        end
      end
      ST_SUB1: begin
        if (byte_i == BYTE_IAC) begin
          state_d = ST_SUB2;
        end
      end
      ST_SUB2: begin
        state_d = (byte_i == BYTE_SE) ? ST_NORMAL : ST_SUB1;
      end
      default: begin
        state_d = data_state;
        res_o   = data_res;
      end
    endcase
    if (!step_i) begin
      res_o.valid = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_NORMAL;
      verb_q      <= VERB_WILL;
      sent_will_q <= 3'b011;
      sent_do_q   <= 3'b110;
    end else if (step_i) begin
      state_q     <= state_d;
      verb_q      <= verb_d;
      sent_will_q <= sent_will_d;
      sent_do_q   <= sent_do_d;
    end
  end

endmodule

// ===== sv/telnet_receive_parser.sv =====
// Telnet receive parser: input word register, parser, result register.
// Any result of a word in the input register is captured in the result register.
// Throughput: one word per cycle unless a held result stalls the parser; the parse
// step is combinational, with the three-entry option match done in parallel.
// Reset (asynchronous, active low) empties both registers, returns the parser to
// normal data and loads the default option table, policies and sent flags.
`timescale 1ns / 1ps

module telnet_receive_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // master side
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] out_byte, [9:8] reply_verb, rest zero
  output logic        m_axis_tuser_o,   // [0] kind
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);
  import trp_pkg::*;

  cfg_t       cfg;
  result_t    res;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  logic       out_kind_q;
  logic [7:0] out_byte_q;
  verb_e      out_verb_q;
  logic       out_free, step;

  trp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // the parser steps whenever the input register holds a word and the result register can take one
  assign out_free        = ~out_valid_q | m_axis_tready_i;
  assign step            = in_valid_q & out_free;
  assign s_axis_tready_o = ~in_valid_q | step;

  trp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res.valid) begin
      out_kind_q <= res.kind;
      out_byte_q <= res.data;
      out_verb_q <= res.verb;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tdata_o  = {6'd0, out_verb_q, out_byte_q};

`ifndef SYNTH
  // a data word always carries a zero verb field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o[9:8] == VERB_WILL))
    else $error("data word with non-zero verb");

  // backpressure upstream only when the input register holds a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> in_valid_q)
    else $error("input stalled while empty");

  // the parser must not step while a result is held back downstream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !step)
    else $error("parser stepped over a stalled result");
`endif

endmodule
